[src/wcpm_pkg.sv]
// wcpm_pkg: shared types and constants of the weighted cross product matrix block
// field widths, request and register codes, controller states, datapath control and status structs
// no dependencies
package wcpm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = 4;
  localparam int ELEM_W   = 10;
  localparam int LEN_W    = 11;
  localparam int PROD_W   = 32;
  localparam int TERM_W   = 33;
  localparam int ACC_W    = 48;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam int DEF_MAX_VECTORS_A = 16;
  localparam int DEF_MAX_VECTORS_B = 16;
  localparam int DEF_MAX_LENGTH    = 1024;

  localparam logic [LEN_W-1:0] VECTOR_LENGTH_RST = LEN_W'(1024);

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_LOAD_M  = 2'd2,
    REQ_COMPUTE = 2'd3
  } req_type_t;

  typedef enum logic [0:0] {
    REG_VECTOR_LENGTH = 1'b0,
    REG_MASK_ENABLE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic issue;
    logic mask_en;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

[src/weighted_cross_product_matrix.sv]
// loads: written to the selected store in the transfer cycle; loads with an out-of-range index are
// dropped; a compute with a zero length or an out-of-range vector index yields a zero result
// flow: loads back to back; a compute holds the input until its result is loaded into the output
// register, after one store read and one multiply-accumulate per element
// reset: synchronous, active low; clears control, vector_length to 1024 and mask_enable to 0;
// sample stores are not cleared
module weighted_cross_product_matrix
  import wcpm_pkg::*;
#(
  parameter int MAX_VECTORS_A = DEF_MAX_VECTORS_A,
  parameter int MAX_VECTORS_B = DEF_MAX_VECTORS_B,
  parameter int MAX_LENGTH    = DEF_MAX_LENGTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // vec_a_index, vec_b_index, elem_index, sample, zero fill
  input  logic [39:0]       in_tdata,
  // req_type
  input  logic [1:0]        in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // product, out_a_index, out_b_index
  output logic [55:0]       out_tdata,
  // saturated
  output logic              out_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int DEPTH_A = MAX_VECTORS_A * MAX_LENGTH;
  localparam int DEPTH_B = MAX_VECTORS_B * MAX_LENGTH;
  localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int AW_M    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  logic [IDX_W-1:0]    in_a_idx, in_b_idx;
  logic [ELEM_W-1:0]   in_elem;
  logic [SAMPLE_W-1:0] in_sample;
  req_type_t           in_req;
  logic                a_ok, b_ok, e_ok;

  logic [LEN_W-1:0]    vector_length_r;
  logic                mask_enable_r;
  logic                cfg_wr;
  cfg_reg_t            cfg_idx;

  state_t              state_r, state_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt, len_clip;
  logic [AW_A-1:0]     base_a_r, base_a_nxt;
  logic [AW_B-1:0]     base_b_r, base_b_nxt;
  logic [IDX_W-1:0]    ia_r, ia_nxt, ib_r, ib_nxt;

  logic                we_a, we_b, we_m, rd_en;
  logic [AW_A-1:0]     waddr_a, raddr_a;
  logic [AW_B-1:0]     waddr_b, raddr_b;
  logic [AW_M-1:0]     waddr_m, raddr_m;
  logic [SAMPLE_W-1:0] rdata_a, rdata_b, rdata_m;

  mac_ctl_t            mac_ctl;
  mac_sts_t            mac_sts;
  logic signed [ACC_W-1:0] acc;
  logic                acc_sat;

  logic                out_load;
  logic                out_valid_r;
  logic [ACC_W-1:0]    out_prod_r;
  logic [IDX_W-1:0]    out_a_r, out_b_r;
  logic                out_sat_r;

  // input unpacking
  assign in_a_idx  = in_tdata[3:0];
  assign in_b_idx  = in_tdata[7:4];
  assign in_elem   = in_tdata[17:8];
  assign in_sample = in_tdata[33:18];
  assign in_req    = req_type_t'(in_tuser);

  assign a_ok = 32'(in_a_idx) < MAX_VECTORS_A;
  assign b_ok = 32'(in_b_idx) < MAX_VECTORS_B;
  assign e_ok = 32'(in_elem) < MAX_LENGTH;

  assign len_clip = (32'(vector_length_r) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : vector_length_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vector_length_r <= VECTOR_LENGTH_RST;
      mask_enable_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_VECTOR_LENGTH: vector_length_r <= cfg_pwdata[LEN_W-1:0];
        REG_MASK_ENABLE:   mask_enable_r   <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_VECTOR_LENGTH: cfg_prdata = CFG_DW'(vector_length_r);
      REG_MASK_ENABLE:   cfg_prdata = CFG_DW'(mask_enable_r);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    base_a_r <= base_a_nxt;
    base_b_r <= base_b_nxt;
    ia_r     <= ia_nxt;
    ib_r     <= ib_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    base_a_nxt = base_a_r;
    base_b_nxt = base_b_r;
    ia_nxt     = ia_r;
    ib_nxt     = ib_r;
    in_tready  = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    we_m       = 1'b0;
    rd_en      = 1'b0;
    mac_ctl    = '{clr: 1'b0, issue: 1'b0, mask_en: mask_enable_r};
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_req)
            REQ_LOAD_A: we_a = a_ok && e_ok;
            REQ_LOAD_B: we_b = b_ok && e_ok;
            REQ_LOAD_M: we_m = e_ok;
            default: begin
              mac_ctl.clr = 1'b1;
              ia_nxt      = in_a_idx;
              ib_nxt      = in_b_idx;
              len_nxt     = len_clip;
              cnt_nxt     = '0;
              base_a_nxt  = AW_A'(32'(in_a_idx) * MAX_LENGTH);
              base_b_nxt  = AW_B'(32'(in_b_idx) * MAX_LENGTH);
              state_nxt   = (a_ok && b_ok && (len_clip != '0)) ? ST_RUN : ST_FINISH;
            end
          endcase
        end
      end
      ST_RUN: begin
        rd_en         = 1'b1;
        mac_ctl.issue = 1'b1;
        if (cnt_r == len_r - LEN_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + LEN_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_sts.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  assign waddr_a = AW_A'(32'(in_a_idx) * MAX_LENGTH + 32'(in_elem));
  assign waddr_b = AW_B'(32'(in_b_idx) * MAX_LENGTH + 32'(in_elem));
  assign waddr_m = AW_M'(in_elem);
  assign raddr_a = base_a_r + AW_A'(cnt_r);
  assign raddr_b = base_b_r + AW_B'(cnt_r);
  assign raddr_m = AW_M'(cnt_r);

  wcpm_mem #(.DEPTH(DEPTH_A), .WIDTH(SAMPLE_W)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  wcpm_mem #(.DEPTH(DEPTH_B), .WIDTH(SAMPLE_W)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  wcpm_mem #(.DEPTH(MAX_LENGTH), .WIDTH(SAMPLE_W)) u_store_m (
    .clk   (clk),
    .we    (we_m),
    .waddr (waddr_m),
    .wdata (in_sample),
    .re    (rd_en),
    .raddr (raddr_m),
    .rdata (rdata_m)
  );

  wcpm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data (rdata_a),
    .b_data (rdata_b),
    .m_data (rdata_m),
    .sts    (mac_sts),
    .acc    (acc),
    .sat    (acc_sat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_prod_r <= acc;
      out_a_r    <= ia_r;
      out_b_r    <= ib_r;
      out_sat_r  <= acc_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_b_r, out_a_r, out_prod_r};
  assign out_tuser  = out_sat_r;

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r < len_r))
    else $error("element counter beyond vector length");

  a_ready_idle_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mac_sts.busy)
    else $error("input taken while terms in flight");

  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_FINISH))
    else $error("result presented outside finish state");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !(we_a || we_b || we_m))
    else $error("store written during product read");

endmodule

[src/wcpm_mem.sv]
// wcpm_mem: single-port-write, single-port-read synchronous sample store
// registered read data; contents undefined until written
// depends on nothing outside this file
module wcpm_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[src/wcpm_mac.sv]
// wcpm_mac: multiply, mask weighting and saturating 48-bit accumulation
// four stages: operand capture (store read register, tracked by v1_r), products, weighted term, accumulate
// depends on wcpm_pkg
module wcpm_mac
  import wcpm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] a_data,
  input  logic signed [SAMPLE_W-1:0] b_data,
  input  logic signed [SAMPLE_W-1:0] m_data,
  output mac_sts_t                   sts,
  output logic signed [ACC_W-1:0]    acc,
  output logic                       sat
);

  logic                     v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0] ab_r, mm_r;
  logic signed [PROD_W-1:0] ab_nxt, mm_nxt;
  logic        [14:0]       m2;
  logic signed [ACC_W-1:0]  wt;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     sat_r, sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 2: raw products, mask square is never negative
  assign ab_nxt = a_data * b_data;
  assign mm_nxt = m_data * m_data;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      ab_r <= ab_nxt;
      mm_r <= mm_nxt;
    end
  end

  // stage 3: squared mask to q1.15, clipped at full scale
  assign m2       = mm_r[30] ? 15'h7fff : mm_r[29:15];
  assign wt       = ab_r * $signed({1'b0, m2});
  assign term_nxt = ctl.mask_en ? TERM_W'(wt >>> 15) : TERM_W'(ab_r);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      term_r <= term_nxt;
    end
  end

  // stage 4: accumulate and clamp each step
  assign sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(term_r);

  always_comb begin
    acc_nxt = acc_r;
    sat_nxt = sat_r;
    if (ctl.clr) begin
      acc_nxt = '0;
      sat_nxt = 1'b0;
    end else if (v3_r) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
  end

  assign sts.busy = v1_r | v2_r | v3_r;
  assign acc      = acc_r;
  assign sat      = sat_r;

  a_clr_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (acc_r == '0) && !sat_r)
    else $error("accumulator not cleared at start of product");

  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !sts.busy && !ctl.issue)
    else $error("accumulator cleared with terms in flight");

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sat_r && !ctl.clr) |=> sat_r)
    else $error("saturation flag lost before product delivered");

endmodule
